@@ rtl/core/assert_macros.svh @@
// assertion macros used by the selector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define RRTS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// same-cycle implication
`define RRTS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rrts_pkg.sv @@
// types and constants of the round robin target selector
package rrts_pkg;

  localparam int SPACE_W = 64;
  localparam int SCORE_W = 16;
  localparam int SLOT_W  = 4;
  localparam int TCNT_W  = 5;

  // request actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [SLOT_W-1:0]  entry_index;
    logic [SPACE_W-1:0] entry_space;
    logic [SCORE_W-1:0] entry_score;
    logic [SCORE_W-1:0] ask_score;
    logic [SPACE_W-1:0] need_bytes;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] target_index;
    logic              preferred;
    logic              none_fit;
    logic              last;
  } res_t;

  // status of the shared remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/rrts_req_if.sv @@
// request channel of the selector
interface rrts_req_if import rrts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/rrts_res_if.sv @@
// result channel of the selector
interface rrts_res_if import rrts_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/round_robin_target_selector_top.sv @@
// round robin target selector: table scan, group split, rotation and result emission
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------------
//   req     | in  | valid/ready   | action, entry_index, space, scores, size
//   res     | out | valid/ready   | target_index, preferred, none_fit, last
//   cfg     | in  | cfg_we        | cfg_wdata = target_count
//
// a load request is written to the table at acceptance; a select runs a table scan,
// a pass of the shared remainder unit for each nonempty group, then a list read
// and an output load for each result; the groups share the one remainder unit
// and the results share the list memory port
// req is ready only in idle; a stalled res holds the sequencer in its emit step
// rst is synchronous; the table has no reset and needs no clearing pass
module round_robin_target_selector_top import rrts_pkg::*; #(
  parameter int MAX_TARGETS  = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TCNT_W-1:0] cfg_wdata,
  rrts_req_if.sink          req,
  rrts_res_if.source        res
);

`include "assert_macros.svh"

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIVP = 3'd2;
  localparam logic [2:0] S_DIVF = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_ELD  = 3'd5;
  localparam logic [2:0] S_NONE = 3'd6;

  logic [2:0]              state;
  logic [TCNT_W-1:0]       tcnt;
  logic [COUNTER_BITS-1:0] rot_ctr;
  logic [COUNTER_BITS-1:0] ctr_snap;
  logic [SPACE_W-1:0]      need;
  logic [SCORE_W-1:0]      blob;
  logic [CNT_W-1:0]        n_cnt;
  logic [CNT_W-1:0]        scan_i;
  logic                    s1_valid;
  logic [IDX_W-1:0]        s1_idx;
  logic [CNT_W-1:0]        npre;
  logic [CNT_W-1:0]        nfal;
  logic [CNT_W-1:0]        sh_pre;
  logic [CNT_W-1:0]        sh_fal;
  logic                    grp;
  logic [CNT_W-1:0]        pos;
  logic [CNT_W-1:0]        emit_j;
  logic                    div_run;
  logic                    res_vld;
  res_t                    res_dat;

  logic                    req_acc;
  logic                    slot_ok;
  logic [CNT_W-1:0]        n_sat;
  logic                    tbl_we;
  logic                    scan_go;
  logic                    scan_end;
  logic [SPACE_W-1:0]      rd_space;
  logic [SCORE_W-1:0]      rd_score;
  logic                    fits;
  logic                    low;
  logic                    list_we;
  logic [IDX_W:0]          list_waddr;
  logic                    list_re;
  logic [IDX_W:0]          list_raddr;
  logic [IDX_W-1:0]        list_q;
  logic [IDX_W-1:0]        list_mem [2*MAX_TARGETS];
  logic                    div_start;
  logic [CNT_W-1:0]        div_dsr;
  div_stat_t               div_st;
  logic [CNT_W-1:0]        div_rem;
  logic [CNT_W-1:0]        grp_cnt;
  logic                    emit_end;
  logic                    out_free;
  logic                    out_ld;
  res_t                    out_next;
  logic [CNT_W:0]          grp_sum;

  // request side
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign slot_ok   = 32'(req.data.entry_index) < MAX_TARGETS;
  assign tbl_we    = req_acc && (req.data.action == ACT_LOAD) && slot_ok;
  assign n_sat     = (32'(tcnt) > MAX_TARGETS) ? CNT_W'(MAX_TARGETS) : CNT_W'(tcnt);

  // scan strobes and compare
  assign scan_go  = (state == S_SCAN) && (scan_i < n_cnt);
  assign scan_end = (state == S_SCAN) && (scan_i == n_cnt) && !s1_valid;
  assign fits     = rd_space >= need;
  assign low      = rd_score <= blob;

  rrts_table #(
    .DEPTH  (MAX_TARGETS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (tbl_we),
    .wr_addr  (IDX_W'(req.data.entry_index)),
    .wr_space (req.data.entry_space),
    .wr_score (req.data.entry_score),
    .rd_en    (scan_go),
    .rd_addr  (scan_i[IDX_W-1:0]),
    .rd_space (rd_space),
    .rd_score (rd_score)
  );

  // group lists: preferred in the lower half, fallback in the upper half
  assign list_we    = (state == S_SCAN) && s1_valid && fits;
  assign list_waddr = low ? {1'b0, npre[IDX_W-1:0]} : {1'b1, nfal[IDX_W-1:0]};
  assign list_re    = (state == S_ERD);
  assign list_raddr = {grp, pos[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= s1_idx;
    end
    if (list_re) begin
      list_q <= list_mem[list_raddr];
    end
  end

  // shared remainder unit, used once per nonempty group
  assign div_start = ((state == S_DIVP) || (state == S_DIVF)) && !div_run;
  assign div_dsr   = (state == S_DIVF) ? nfal : npre;

  rrts_mod #(
    .DVD_W (COUNTER_BITS),
    .DSR_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ctr_snap),
    .divisor  (div_dsr),
    .stat     (div_st),
    .rem      (div_rem)
  );

  // emission
  assign grp_cnt  = grp ? nfal : npre;
  assign emit_end = CNT_W'(emit_j + 1'b1) == grp_cnt;
  assign out_free = !res_vld || res.ready;
  assign out_ld   = ((state == S_ELD) || (state == S_NONE)) && out_free;
  assign grp_sum  = (CNT_W+1)'(npre) + (CNT_W+1)'(nfal);

  always_comb begin
    if (state == S_NONE) begin
      out_next.target_index = '0;
      out_next.preferred    = 1'b0;
      out_next.none_fit     = 1'b1;
      out_next.last         = 1'b1;
    end else begin
      out_next.target_index = SLOT_W'(list_q);
      out_next.preferred    = !grp;
      out_next.none_fit     = 1'b0;
      out_next.last         = emit_end && (grp || (nfal == '0));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (out_ld) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      res_dat <= out_next;
    end
  end

  assign res.valid = res_vld;
  assign res.data  = res_dat;

  // target count register
  always_ff @(posedge clk) begin
    if (rst) begin
      tcnt <= '0;
    end else if (cfg_we) begin
      tcnt <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rot_ctr  <= '0;
      div_run  <= 1'b0;
      n_cnt    <= '0;
      npre     <= '0;
      nfal     <= '0;
      s1_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc && (req.data.action == ACT_SELECT)) begin
            need     <= req.data.need_bytes;
            blob     <= req.data.ask_score;
            n_cnt    <= n_sat;
            npre     <= '0;
            nfal     <= '0;
            scan_i   <= '0;
            s1_valid <= 1'b0;
            state    <= (n_sat == '0) ? S_NONE : S_SCAN;
          end
        end
        S_SCAN: begin
          s1_valid <= scan_go;
          s1_idx   <= scan_i[IDX_W-1:0];
          if (scan_go) begin
            scan_i <= CNT_W'(scan_i + 1'b1);
          end
          if (s1_valid && fits) begin
            if (low) begin
              npre <= CNT_W'(npre + 1'b1);
            end else begin
              nfal <= CNT_W'(nfal + 1'b1);
            end
          end
          if (scan_end) begin
            ctr_snap <= rot_ctr;
            rot_ctr  <= COUNTER_BITS'(rot_ctr + 1'b1);
            if (npre != '0) begin
              state <= S_DIVP;
            end else if (nfal != '0) begin
              state <= S_DIVF;
            end else begin
              state <= S_NONE;
            end
          end
        end
        S_DIVP: begin
          if (div_start) begin
            div_run <= 1'b1;
          end
          if (div_st.done) begin
            div_run <= 1'b0;
            sh_pre  <= div_rem;
            if (nfal != '0) begin
              state <= S_DIVF;
            end else begin
              grp    <= 1'b0;
              pos    <= div_rem;
              emit_j <= '0;
              state  <= S_ERD;
            end
          end
        end
        S_DIVF: begin
          if (div_start) begin
            div_run <= 1'b1;
          end
          if (div_st.done) begin
            div_run <= 1'b0;
            sh_fal  <= div_rem;
            emit_j  <= '0;
            if (npre != '0) begin
              grp <= 1'b0;
              pos <= sh_pre;
            end else begin
              grp <= 1'b1;
              pos <= div_rem;
            end
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          if (out_ld) begin
            if (emit_end) begin
              if (!grp && (nfal != '0)) begin
                grp    <= 1'b1;
                pos    <= sh_fal;
                emit_j <= '0;
                state  <= S_ERD;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              pos    <= (CNT_W'(pos + 1'b1) == grp_cnt) ? '0 : CNT_W'(pos + 1'b1);
              emit_j <= CNT_W'(emit_j + 1'b1);
              state  <= S_ERD;
            end
          end
        end
        S_NONE: begin
          if (out_ld) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `RRTS_ASSERT(a_cnt_fit, clk, rst, grp_sum <= (CNT_W+1)'(n_cnt), "group sizes exceed scan length")
  `RRTS_ASSERT_IMP(a_pos_range, clk, rst, state == S_ERD, pos < grp_cnt, "rotation position out of group")
  `RRTS_ASSERT_NXT(a_last_idle, clk, rst, out_ld && out_next.last, state == S_IDLE, "last result without return to idle")
  `RRTS_ASSERT_IMP(a_ctr_step, clk, rst, rot_ctr != $past(rot_ctr), $past(state) == S_SCAN, "rotation counter moved outside scan end")

endmodule

@@ rtl/core/rrts_table.sv @@
// target table memory: space and score per slot, one write and one registered read
module rrts_table import rrts_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [SPACE_W-1:0] wr_space,
  input  logic [SCORE_W-1:0] wr_score,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [SPACE_W-1:0] rd_space,
  output logic [SCORE_W-1:0] rd_score
);

  logic [SPACE_W-1:0] space_mem [DEPTH];
  logic [SCORE_W-1:0] score_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      space_mem[wr_addr] <= wr_space;
      score_mem[wr_addr] <= wr_score;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_space <= space_mem[rd_addr];
      rd_score <= score_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/rrts_mod.sv @@
// shared remainder unit: restoring division, one dividend bit per cycle
module rrts_mod import rrts_pkg::*; #(
  parameter int DVD_W = 32,
  parameter int DSR_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DSR_W-1:0] rem
);

  localparam int BC_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [BC_W-1:0]  bit_cnt;
  logic             busy;
  logic             done;
  logic [DSR_W:0]   trial;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, dvd[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        dvd     <= dividend;
        dsr     <= divisor;
        rem     <= '0;
        bit_cnt <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= DSR_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DSR_W-1:0];
        end
        dvd     <= dvd << 1;
        bit_cnt <= BC_W'(bit_cnt + 1'b1);
        if (bit_cnt == BC_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ tb/tb_round_robin_target_selector_top.sv @@
// self-checking testbench for the round robin target selector
module tb_round_robin_target_selector_top;
  import rrts_pkg::*;

  localparam int MAX_TARGETS   = 16;
  localparam int COUNTER_BITS  = 32;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 42;

  // tracks the target table and rotation, predicts the picks of each select
  class pick_board;
    logic [SPACE_W-1:0] space_tab [MAX_TARGETS];
    logic [SCORE_W-1:0] score_tab [MAX_TARGETS];
    logic [COUNTER_BITS-1:0] rr_count;
    logic [TCNT_W-1:0] active_count;
    res_t expected_picks [$];
    int errors;
    int loads;
    int selects;
    int misses;
    int checked;

    function new();
      rr_count = '0;
      active_count = '0;
      errors = 0;
      loads = 0;
      selects = 0;
      misses = 0;
      checked = 0;
    endfunction

    function void set_count(logic [TCNT_W-1:0] v);
      active_count = v;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function void add_pick(int unsigned idx, bit pref, bit none, bit fin);
      res_t p;
      p.target_index = idx[SLOT_W-1:0];
      p.preferred = pref;
      p.none_fit = none;
      p.last = fin;
      expected_picks.insert(expected_picks.size(), p);
    endfunction

    // accepted request: update the table or predict the ordered picks
    function void note_request(req_t r);
      int unsigned pref_q [$];
      int unsigned fall_q [$];
      int unsigned n;
      int unsigned total;
      int unsigned k;
      int unsigned sh;
      logic [COUNTER_BITS-1:0] rot;
      if (r.action == ACT_LOAD) begin
        space_tab[r.entry_index] = r.entry_space;
        score_tab[r.entry_index] = r.entry_score;
        loads++;
        return;
      end
      selects++;
      n = (active_count > MAX_TARGETS) ? MAX_TARGETS : active_count;
      // empty table: no fit and the rotation stays put
      if (n == 0) begin
        misses++;
        add_pick(0, 0, 1, 1);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (space_tab[i] >= r.need_bytes) begin
          if (score_tab[i] <= r.ask_score) pref_q.insert(pref_q.size(), i);
          else fall_q.insert(fall_q.size(), i);
        end
      end
      rot = rr_count;
      rr_count = rr_count + 1'b1;
      total = pref_q.size() + fall_q.size();
      if (total == 0) begin
        misses++;
        add_pick(0, 0, 1, 1);
        return;
      end
      // preferred group first, each group rotated by the counter
      k = 0;
      if (pref_q.size() > 0) begin
        sh = rot % pref_q.size();
        for (int unsigned i = 0; i < pref_q.size(); i++) begin
          add_pick(pref_q[(i + sh) % pref_q.size()], 1, 0, k + 1 == total);
          k++;
        end
      end
      if (fall_q.size() > 0) begin
        sh = rot % fall_q.size();
        for (int unsigned i = 0; i < fall_q.size(); i++) begin
          add_pick(fall_q[(i + sh) % fall_q.size()], 0, 0, k + 1 == total);
          k++;
        end
      end
    endfunction

    // accepted result against the oldest prediction
    function void check_pick(res_t got);
      res_t want;
      if (expected_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result idx=%0d pref=%0b none=%0b last=%0b", $time,
                 got.target_index, got.preferred, got.none_fit, got.last);
        return;
      end
      want = expected_picks.pop_front();
      checked++;
      if (got.target_index !== want.target_index || got.preferred !== want.preferred ||
          got.none_fit !== want.none_fit || got.last !== want.last) begin
        errors++;
        $display("%0t: mismatch expected idx=%0d pref=%0b none=%0b last=%0b", $time,
                 want.target_index, want.preferred, want.none_fit, want.last);
        $display("%0t:          actual   idx=%0d pref=%0b none=%0b last=%0b", $time,
                 got.target_index, got.preferred, got.none_fit, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [TCNT_W-1:0] cfg_wdata;
  int src_idle_pct;
  int snk_idle_pct;
  logic hold_ask;
  int counts_used;
  pick_board board;

  rrts_req_if req_ch ();
  rrts_res_if res_ch ();

  round_robin_target_selector_top #(
    .MAX_TARGETS (MAX_TARGETS),
    .COUNTER_BITS(COUNTER_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .res      (res_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random ready, one long hold-off on request, check accepted results
  int hold_left = 0;
  bit hold_taken = 0;
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) board.check_pick(res_ch.data);
    if (hold_ask && !hold_taken) begin
      hold_taken = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles with no request or result moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // random byte counts, biased toward small values and the extremes
  function automatic logic [SPACE_W-1:0] pick_bytes();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return {$urandom, $urandom};
      default: return SPACE_W'($urandom_range(4096));
    endcase
  endfunction

  // random scores, often tied so that equal compares happen
  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(4))
      0: return SCORE_W'($urandom_range(3));
      1: return $urandom_range(1) ? '1 : '0;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic req_t make_load(int unsigned idx, logic [SPACE_W-1:0] sp,
                                     logic [SCORE_W-1:0] sc);
    req_t r;
    r.action = ACT_LOAD;
    r.entry_index = idx[SLOT_W-1:0];
    r.entry_space = sp;
    r.entry_score = sc;
    r.ask_score = SCORE_W'($urandom);
    r.need_bytes = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t make_select(logic [SPACE_W-1:0] need, logic [SCORE_W-1:0] blob);
    req_t r;
    r.action = ACT_SELECT;
    r.entry_index = SLOT_W'($urandom);
    r.entry_space = {$urandom, $urandom};
    r.entry_score = SCORE_W'($urandom);
    r.ask_score = blob;
    r.need_bytes = need;
    return r;
  endfunction

  // offer one request after random idle cycles, return at its acceptance
  task automatic push_request(req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(r);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // target count write, only with the block idle
  task automatic write_count(logic [TCNT_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(v);
    counts_used++;
  endtask

  // one random phase under a given count and idle mix
  task automatic random_phase(logic [TCNT_W-1:0] cnt, int s_idle, int r_idle, int pause_at,
                              bit with_hold);
    write_count(cnt);
    src_idle_pct = s_idle;
    snk_idle_pct = r_idle;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == pause_at) drain();
      if (with_hold && i == 8) hold_ask <= 1'b1;
      if ($urandom_range(99) < 40)
        push_request(make_load($urandom_range(MAX_TARGETS - 1), pick_bytes(), pick_score()));
      else
        push_request(make_select(pick_bytes(), pick_score()));
    end
  endtask

  // stimulus
  initial begin
    board = new();
    counts_used = 0;
    src_idle_pct = 7;
    snk_idle_pct = 70;
    hold_ask <= 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count still zero after reset: no fit, no rotation
    push_request(make_select('0, '1));

    // fill every slot: space extremes and mid values, scores extremes and mid values
    for (int i = 0; i < MAX_TARGETS; i++) begin
      push_request(make_load(i,
        (i == 0) ? SPACE_W'(50) : (i % 4 == 0) ? '1 : (i % 4 == 1) ? '0 : SPACE_W'(100 * i),
        (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : SCORE_W'(100 * i)));
    end

    // full table: all fit, split by score, only the largest spaces, mid sizes
    write_count(TCNT_W'(MAX_TARGETS));
    push_request(make_select('0, '1));
    push_request(make_select('0, '0));
    push_request(make_select('1, '0));
    push_request(make_select(SPACE_W'(500), 16'h8000));
    push_request(make_select(SPACE_W'(1), 16'h7fff));
    push_request(make_select('0, SCORE_W'(500)));

    // one slot in use and it is too small: no fit, rotation still advances
    write_count(TCNT_W'(1));
    push_request(make_select('1, '1));

    // random phases: sender idles little then much, then no idling at all
    random_phase(TCNT_W'(MAX_TARGETS), 7, 70, -1, 1);
    random_phase('1, 7, 70, -1, 0);
    random_phase(TCNT_W'(MAX_TARGETS + 1), 70, 7, 20, 0);
    random_phase(TCNT_W'(1), 70, 7, -1, 0);
    random_phase(TCNT_W'($urandom_range(2, MAX_TARGETS - 1)), 0, 0, -1, 0);
    random_phase(TCNT_W'(MAX_TARGETS), 0, 0, -1, 0);

    // wait out every result and the block's own latency
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d predicted results never arrived", $time, board.pending());
    end
    $display("covered %0d loads and %0d selects (%0d with no fit) under %0d target counts",
             board.loads, board.selects, board.misses, counts_used);
    $display("checked %0d results, %0d errors", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
